[src/tfs_pkg.sv]
package tfs_pkg;

    // Fixed field widths
    localparam int IN_W     = 32;
    localparam int DIGITS   = 10;                 // decimal digits of a 32-bit count
    localparam int BCD_W    = DIGITS * 4;
    localparam int DIG_IDX_W = $clog2(DIGITS);
    localparam int CNT_W    = $clog2(DIGITS + 1);
    localparam int BITS_W   = $clog2(IN_W + 1);
    localparam int STEP_W   = 5;
    localparam int LANES    = 3;

    // Frame constants
    localparam logic [7:0] SYNC0    = 8'hFF;
    localparam logic [7:0] SYNC1    = 8'hFE;
    localparam logic [7:0] COMMA    = 8'h2C;
    localparam logic [7:0] ZERO_B   = 8'h00;
    localparam logic [7:0] ASCII_0  = 8'h30;

    // Byte source for an emit step
    typedef enum logic [3:0] {
        SRC_LIT,
        SRC_MLEN_LO,
        SRC_LEN_CHK,
        SRC_TOPIC_LO,
        SRC_TOPIC_HI,
        SRC_SLEN_LO,
        SRC_DIGIT,
        SRC_MSG_CHK
    } t_src;

    // Condition that keeps the sequencer on the current step
    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_NO_REQ,
        HOLD_CONV,
        HOLD_DIGITS
    } t_hold;

    // One microcode word
    typedef struct packed {
        t_src              src;
        logic [7:0]        lit;
        logic [1:0]        lane;
        t_hold             hold;
        logic              take;
        logic              emit;
        logic              add_sum;
        logic              last;
        logic              load_dig;
        logic [STEP_W-1:0] nxt;
    } t_ctrl;

    // Status fed back to the sequencer
    typedef struct packed {
        logic in_valid;
        logic conv_busy;
        logic dig_more;
        logic out_free;
    } t_stat;

    typedef logic [BCD_W-1:0] t_bcd;
    typedef logic [CNT_W-1:0] t_cnt;

endpackage

[src/tfs_bcd_conv.sv]
module tfs_bcd_conv #(
    parameter int VALUE_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tfs_pkg::IN_W-1:0]   i_val [tfs_pkg::LANES],
    output logic                       o_busy,
    output tfs_pkg::t_bcd              o_bcd [tfs_pkg::LANES],
    output tfs_pkg::t_cnt              o_cnt [tfs_pkg::LANES]
);

    localparam int VB_EFF = (VALUE_BITS > tfs_pkg::IN_W) ? tfs_pkg::IN_W : VALUE_BITS;
    localparam int SHIFT  = tfs_pkg::IN_W - VB_EFF;

    logic [tfs_pkg::BITS_W-1:0] r_bits;
    logic [tfs_pkg::IN_W-1:0]   r_bin [tfs_pkg::LANES];
    tfs_pkg::t_bcd              r_bcd [tfs_pkg::LANES];
    tfs_pkg::t_bcd              adj   [tfs_pkg::LANES];

    assign o_busy = (r_bits != '0);

    // Shift-count: one input bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
        end else if (i_start) begin
            r_bits <= tfs_pkg::BITS_W'(VB_EFF);
        end else if (o_busy) begin
            r_bits <= r_bits - 1'b1;
        end
    end

    for (genvar l = 0; l < tfs_pkg::LANES; l++) begin : g_lane
        // Add 3 to every digit of 5 or more before the shift
        always_comb begin
            for (int d = 0; d < tfs_pkg::DIGITS; d++) begin
                if (r_bcd[l][d*4 +: 4] >= 4'd5) begin
                    adj[l][d*4 +: 4] = r_bcd[l][d*4 +: 4] + 4'd3;
                end else begin
                    adj[l][d*4 +: 4] = r_bcd[l][d*4 +: 4];
                end
            end
        end

        // Binary in at the bottom of the BCD word, top bit first
        always_ff @(posedge i_clk) begin
            if (i_start) begin
                r_bin[l] <= i_val[l] << SHIFT;
                r_bcd[l] <= '0;
            end else if (o_busy) begin
                r_bin[l] <= {r_bin[l][tfs_pkg::IN_W-2:0], 1'b0};
                r_bcd[l] <= {adj[l][tfs_pkg::BCD_W-2:0], r_bin[l][tfs_pkg::IN_W-1]};
            end
        end

        // Digit count: position of the top nonzero digit, at least one
        always_comb begin
            o_cnt[l] = tfs_pkg::CNT_W'(1);
            for (int d = 0; d < tfs_pkg::DIGITS; d++) begin
                if (r_bcd[l][d*4 +: 4] != 4'd0) begin
                    o_cnt[l] = tfs_pkg::CNT_W'(d + 1);
                end
            end
        end

        assign o_bcd[l] = r_bcd[l];
    end

endmodule

[src/tfs_sequencer.sv]
module tfs_sequencer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tfs_pkg::t_stat  i_stat,
    output tfs_pkg::t_ctrl  o_ctrl,
    output logic            o_fire
);

    logic [tfs_pkg::STEP_W-1:0] r_step;
    logic [tfs_pkg::STEP_W-1:0] n_step;
    logic                       hold;

    // Microcode ROM: one word per step
    function automatic tfs_pkg::t_ctrl rom(input logic [tfs_pkg::STEP_W-1:0] s);
        tfs_pkg::t_ctrl w;
        w = '{src: tfs_pkg::SRC_LIT, lit: tfs_pkg::ZERO_B, lane: 2'd0,
              hold: tfs_pkg::HOLD_NONE, take: 1'b0, emit: 1'b1, add_sum: 1'b0,
              last: 1'b0, load_dig: 1'b0, nxt: s + 1'b1};
        unique case (s)
            5'd0: begin  // wait for a request
                w.emit = 1'b0; w.take = 1'b1; w.hold = tfs_pkg::HOLD_NO_REQ;
            end
            5'd1: begin  // binary to BCD
                w.emit = 1'b0; w.hold = tfs_pkg::HOLD_CONV;
            end
            5'd2:  w.lit = tfs_pkg::SYNC0;
            5'd3:  w.lit = tfs_pkg::SYNC1;
            5'd4:  w.src = tfs_pkg::SRC_MLEN_LO;
            5'd5:  w.lit = tfs_pkg::ZERO_B;          // message length high byte
            5'd6:  w.src = tfs_pkg::SRC_LEN_CHK;
            5'd7: begin
                w.src = tfs_pkg::SRC_TOPIC_LO; w.add_sum = 1'b1;
            end
            5'd8: begin
                w.src = tfs_pkg::SRC_TOPIC_HI; w.add_sum = 1'b1;
            end
            5'd9: begin
                w.src = tfs_pkg::SRC_SLEN_LO; w.add_sum = 1'b1;
            end
            5'd10, 5'd11: w.add_sum = 1'b1;          // string length upper bytes
            5'd12: begin
                w.add_sum = 1'b1; w.load_dig = 1'b1; w.lane = 2'd0;
            end
            5'd13: begin
                w.src = tfs_pkg::SRC_DIGIT; w.add_sum = 1'b1; w.lane = 2'd0;
                w.hold = tfs_pkg::HOLD_DIGITS;
            end
            5'd14: begin
                w.lit = tfs_pkg::COMMA; w.add_sum = 1'b1; w.load_dig = 1'b1;
                w.lane = 2'd1;
            end
            5'd15: begin
                w.src = tfs_pkg::SRC_DIGIT; w.add_sum = 1'b1; w.lane = 2'd1;
                w.hold = tfs_pkg::HOLD_DIGITS;
            end
            5'd16: begin
                w.lit = tfs_pkg::COMMA; w.add_sum = 1'b1; w.load_dig = 1'b1;
                w.lane = 2'd2;
            end
            5'd17: begin
                w.src = tfs_pkg::SRC_DIGIT; w.add_sum = 1'b1; w.lane = 2'd2;
                w.hold = tfs_pkg::HOLD_DIGITS;
            end
            5'd18: begin
                w.src = tfs_pkg::SRC_MSG_CHK; w.last = 1'b1; w.nxt = '0;
            end
            default: begin
                w.emit = 1'b0; w.nxt = '0;
            end
        endcase
        return w;
    endfunction

    assign o_ctrl = rom(r_step);

    // A step with a byte waits for a free output register
    assign o_fire = !o_ctrl.emit || i_stat.out_free;

    // Stay conditions
    always_comb begin
        unique case (o_ctrl.hold)
            tfs_pkg::HOLD_NONE:   hold = 1'b0;
            tfs_pkg::HOLD_NO_REQ: hold = !i_stat.in_valid;
            tfs_pkg::HOLD_CONV:   hold = i_stat.conv_busy;
            tfs_pkg::HOLD_DIGITS: hold = i_stat.dig_more;
            default:              hold = 1'b0;
        endcase
    end

    // Step counter
    always_comb begin
        n_step = r_step;
        if (o_fire && !hold) begin
            n_step = o_ctrl.nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

[src/telemetry_frame_serializer.sv]
// Telemetry frame serializer: each accepted request of three unsigned counts
// (left, right, time) produces one frame, one byte per output transfer:
// sync FF FE, 16-bit message length, length checksum, 16-bit topic id, 32-bit
// string length, "L,R,T" in decimal ASCII and a closing checksum, with
// o_last_byte set on that final byte. All multi-byte fields are little-endian.
// A frame is 14 bytes plus the digit count (17 to 44 bytes for 32-bit counts).
// One request is accepted, then converted over VALUE_BITS (at most 32) bits in
// the bit-serial binary-to-BCD converter, then sent byte by byte, stalling
// while the sink is not ready. The next request is taken once the final byte
// is in the output register. Write topic_id through i_cfg_we / i_cfg_data only
// between frames; it resets to 0.
module telemetry_frame_serializer #(
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_left_count,
    input  logic [31:0] i_right_count,
    input  logic [31:0] i_time_stamp,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte
);

    tfs_pkg::t_ctrl ctrl;
    tfs_pkg::t_stat stat;
    logic           fire;
    logic           accept;
    logic           conv_busy;

    logic [tfs_pkg::IN_W-1:0] vals [tfs_pkg::LANES];
    tfs_pkg::t_bcd            bcd  [tfs_pkg::LANES];
    tfs_pkg::t_cnt            cnt  [tfs_pkg::LANES];

    logic [15:0]                   r_topic;
    logic [7:0]                    r_sum;
    logic [tfs_pkg::DIG_IDX_W-1:0] r_dig_idx;
    logic                          r_out_valid;
    logic [7:0]                    r_out_byte;
    logic                          r_out_last;

    logic [5:0]                    str_len;
    logic [7:0]                    mlen_lo;
    logic [7:0]                    byte_val;
    tfs_pkg::t_bcd                 lane_bcd;
    tfs_pkg::t_cnt                 lane_cnt;

    assign vals[0] = i_left_count;
    assign vals[1] = i_right_count;
    assign vals[2] = i_time_stamp;

    assign o_in_ready = ctrl.take;
    assign accept     = i_in_valid && ctrl.take;

    tfs_bcd_conv #(
        .VALUE_BITS(VALUE_BITS)
    ) u_conv (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(accept),
        .i_val  (vals),
        .o_busy (conv_busy),
        .o_bcd  (bcd),
        .o_cnt  (cnt)
    );

    assign stat.in_valid  = i_in_valid;
    assign stat.conv_busy = conv_busy;
    assign stat.dig_more  = (r_dig_idx != '0);
    assign stat.out_free  = !r_out_valid || i_out_ready;

    tfs_sequencer u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_stat (stat),
        .o_ctrl (ctrl),
        .o_fire (fire)
    );

    // Topic register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_topic <= '0;
        end else if (i_cfg_we) begin
            r_topic <= i_cfg_data;
        end
    end

    // Lengths: digits plus two commas; message adds four
    assign str_len = {2'b00, cnt[0]} + {2'b00, cnt[1]} + {2'b00, cnt[2]} + 6'd2;
    assign mlen_lo = {2'b00, str_len} + 8'd4;

    assign lane_bcd = bcd[ctrl.lane];
    assign lane_cnt = cnt[ctrl.lane];

    // Byte mux
    always_comb begin
        case (ctrl.src)
            tfs_pkg::SRC_LIT:      byte_val = ctrl.lit;
            tfs_pkg::SRC_MLEN_LO:  byte_val = mlen_lo;
            tfs_pkg::SRC_LEN_CHK:  byte_val = ~mlen_lo;     // high byte is zero
            tfs_pkg::SRC_TOPIC_LO: byte_val = r_topic[7:0];
            tfs_pkg::SRC_TOPIC_HI: byte_val = r_topic[15:8];
            tfs_pkg::SRC_SLEN_LO:  byte_val = {2'b00, str_len};
            tfs_pkg::SRC_DIGIT:
                byte_val = tfs_pkg::ASCII_0 | {4'd0, lane_bcd[r_dig_idx*4 +: 4]};
            tfs_pkg::SRC_MSG_CHK:  byte_val = ~r_sum;
            default:               byte_val = ctrl.lit;
        endcase
    end

    // Digit pointer: top digit first, counts down to the units digit
    always_ff @(posedge i_clk) begin
        if (fire && ctrl.emit) begin
            if (ctrl.load_dig) begin
                r_dig_idx <= tfs_pkg::DIG_IDX_W'(lane_cnt - 1'b1);
            end else if (ctrl.src == tfs_pkg::SRC_DIGIT && r_dig_idx != '0) begin
                r_dig_idx <= r_dig_idx - 1'b1;
            end
        end
    end

    // Running message checksum
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sum <= '0;
        end else if (fire && ctrl.emit && ctrl.add_sum) begin
            r_sum <= r_sum + byte_val;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && ctrl.emit) begin
            r_out_byte <= byte_val;
            r_out_last <= ctrl.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_out_last;

endmodule
